@@ sv/assert_macros.svh @@
// Assertion macros for the RTL, included by pointer_viewport_tracker_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every aclk edge outside reset.
`define PVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every aclk edge, reset included.
`define PVT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/pvt_pkg.sv @@
// Types and constants of the pointer viewport tracker.
package pvt_pkg;

    localparam int MAX_SCREEN = 4096;
    localparam int POS_W      = $clog2(MAX_SCREEN);
    localparam int SIZE_W     = POS_W + 1;
    localparam int AX_W       = POS_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SIZE_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_BITS   = 4 * POS_W + 5;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_COLS   = 3'd0,
        REG_VIEW_ROWS   = 3'd1,
        REG_REMOTE_COLS = 3'd2,
        REG_REMOTE_ROWS = 3'd3,
        REG_PAUSED      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] off;
    } axis_res_t;

endpackage

@@ sv/pvt_axis.sv @@
// One axis: pan the window when the pointer leaves it, then clamp the pointer.
module pvt_axis
    import pvt_pkg::*;
(
    input  logic signed [AX_W-1:0]   pos_in,
    input  logic        [POS_W-1:0]  off_in,
    input  logic        [SIZE_W-1:0] view,
    input  logic        [SIZE_W-1:0] remote,
    output axis_res_t                res
);

    logic signed [AX_W-1:0] view_s, remote_s, half_s, span_s, off_s;
    logic signed [AX_W-1:0] o0, o1, o2, dn, up, end1, hi, p;

    always_comb begin
        view_s   = $signed({{(AX_W-SIZE_W){1'b0}}, view});
        remote_s = $signed({{(AX_W-SIZE_W){1'b0}}, remote});
        half_s   = $signed({{(AX_W-SIZE_W+1){1'b0}}, view[SIZE_W-1:1]});
        off_s    = $signed({{(AX_W-POS_W){1'b0}}, off_in});
        span_s   = remote_s - view_s;

        o0 = (off_s > span_s) ? span_s : off_s;

        dn = o0 - half_s;
        o1 = o0;
        if (pos_in < o0) begin
            o1 = (dn < $signed(AX_W'(0))) ? $signed(AX_W'(0)) : dn;
        end

        end1 = o1 + view_s;
        up   = o1 + half_s;
        o2   = o1;
        if ((pos_in >= end1) && (end1 < remote_s)) begin
            o2 = (up > span_s) ? span_s : up;
        end

        hi = o2 + view_s - $signed(AX_W'(1));
        if (pos_in < o2) begin
            p = o2;
        end else if (pos_in > hi) begin
            p = hi;
        end else begin
            p = pos_in;
        end

        res.pos = p[POS_W-1:0];
        res.off = o2[POS_W-1:0];
    end

endmodule

@@ sv/pointer_viewport_tracker_core.sv @@
// Top level of the pointer viewport tracker: stream ports, state and result register.
// Takes one word per clock unless a full output register stalls. A word sits in
// the input register, where one pass of add, compare and clamp logic per axis
// updates the pointer and window offset, and the result lands in the output
// register, which drives m_tvalid. Start words and words taken while drawing
// is paused update state (or not) and give no result. The output register
// parts the two sides, so a word is taken while the last result waits for
// m_tready; a full output register holds the next word in the input register.
`include "assert_macros.svh"

module pointer_viewport_tracker_core
    import pvt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // buttons[7:0], delta_x[15:8], delta_y[23:16], wheel[31:24]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pointer_col[11:0], pointer_row[23:12], button_mask[28:24],
    // offset_col[40:29], offset_row[52:41], zero fill above
    output logic [OUT_DATA_W-1:0] m_tdata,
    // refresh_needed[0]
    output logic [0:0]            m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIZE_W-1:0] view_cols_reg, view_rows_reg, remote_cols_reg, remote_rows_reg;
    logic              paused_reg;

    logic              in_valid_reg;
    logic              in_action_reg;
    logic [7:0]        in_buttons_reg;
    logic signed [7:0] in_dx_reg, in_dy_reg, in_wheel_reg;

    logic [POS_W-1:0]  cursor_col_reg, cursor_row_reg, view_left_reg, view_top_reg;

    logic              out_valid_reg;
    logic [POS_W-1:0]  pcol_reg, prow_reg, ocol_reg, orow_reg;
    logic [4:0]        mask_reg;
    logic              refresh_reg;

    logic [SIZE_W-1:0] rc, rr, vc, vr;
    logic signed [AX_W-1:0] col_sum, row_sum;
    axis_res_t         col_res, row_res;
    logic              advance, produce;
    logic [4:0]        mask_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_cols_reg   <= SIZE_W'(640);
            view_rows_reg   <= SIZE_W'(480);
            remote_cols_reg <= SIZE_W'(640);
            remote_rows_reg <= SIZE_W'(480);
            paused_reg      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_VIEW_COLS:   view_cols_reg   <= cfg_data;
                REG_VIEW_ROWS:   view_rows_reg   <= cfg_data;
                REG_REMOTE_COLS: remote_cols_reg <= cfg_data;
                REG_REMOTE_ROWS: remote_rows_reg <= cfg_data;
                REG_PAUSED:      paused_reg      <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // effective sizes
    always_comb begin
        if (remote_cols_reg == '0) begin
            rc = SIZE_W'(1);
        end else if (remote_cols_reg > SIZE_W'(MAX_SCREEN)) begin
            rc = SIZE_W'(MAX_SCREEN);
        end else begin
            rc = remote_cols_reg;
        end
        if (remote_rows_reg == '0) begin
            rr = SIZE_W'(1);
        end else if (remote_rows_reg > SIZE_W'(MAX_SCREEN)) begin
            rr = SIZE_W'(MAX_SCREEN);
        end else begin
            rr = remote_rows_reg;
        end
        if (view_cols_reg == '0) begin
            vc = SIZE_W'(1);
        end else if (view_cols_reg > rc) begin
            vc = rc;
        end else begin
            vc = view_cols_reg;
        end
        if (view_rows_reg == '0) begin
            vr = SIZE_W'(1);
        end else if (view_rows_reg > rr) begin
            vr = rr;
        end else begin
            vr = view_rows_reg;
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign produce  = !in_action_reg && !paused_reg;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg  <= s_tuser[0];
            in_buttons_reg <= s_tdata[7:0];
            in_dx_reg      <= s_tdata[15:8];
            in_dy_reg      <= s_tdata[23:16];
            in_wheel_reg   <= s_tdata[31:24];
        end
    end

    assign col_sum = $signed({{(AX_W-POS_W){1'b0}}, cursor_col_reg})
                   + $signed({{(AX_W-8){in_dx_reg[7]}}, in_dx_reg});
    assign row_sum = $signed({{(AX_W-POS_W){1'b0}}, cursor_row_reg})
                   - $signed({{(AX_W-8){in_dy_reg[7]}}, in_dy_reg});

    pvt_axis u_axis_col (
        .pos_in (col_sum),
        .off_in (view_left_reg),
        .view   (vc),
        .remote (rc),
        .res    (col_res)
    );

    pvt_axis u_axis_row (
        .pos_in (row_sum),
        .off_in (view_top_reg),
        .view   (vr),
        .remote (rr),
        .res    (row_res)
    );

    always_comb begin
        mask_next[0] = in_buttons_reg[0];
        mask_next[1] = in_buttons_reg[2];
        mask_next[2] = in_buttons_reg[1];
        mask_next[3] = (in_wheel_reg > 8'sd0);
        mask_next[4] = in_wheel_reg[7];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            view_left_reg  <= '0;
            view_top_reg   <= '0;
        end else if (advance) begin
            if (in_action_reg) begin
                cursor_col_reg <= vc[SIZE_W-1:1];
                cursor_row_reg <= vr[SIZE_W-1:1];
                view_left_reg  <= '0;
                view_top_reg   <= '0;
            end else if (!paused_reg) begin
                cursor_col_reg <= col_res.pos;
                cursor_row_reg <= row_res.pos;
                view_left_reg  <= col_res.off;
                view_top_reg   <= row_res.off;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= advance && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produce) begin
            pcol_reg    <= col_res.pos;
            prow_reg    <= row_res.pos;
            ocol_reg    <= col_res.off;
            orow_reg    <= row_res.off;
            mask_reg    <= mask_next;
            refresh_reg <= (col_res.off != view_left_reg) || (row_res.off != view_top_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}},
                       orow_reg, ocol_reg, mask_reg, prow_reg, pcol_reg};
    assign m_tuser  = refresh_reg;

    `PVT_ASSERT(a_col_in_window, out_valid_reg |-> (pcol_reg >= ocol_reg), "pointer col left of window")
    `PVT_ASSERT(a_row_in_window, out_valid_reg |-> (prow_reg >= orow_reg), "pointer row above window")
    `PVT_ASSERT(a_start_clears, (advance && in_action_reg) |=> ((view_left_reg == '0) && (view_top_reg == '0)), "start left offsets set")
    `PVT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!out_valid_reg && !in_valid_reg), "valid after reset")

endmodule

@@ bench/tb_pointer_viewport_tracker_core.sv @@
// Self-checking testbench for pointer_viewport_tracker_core: directed and random stream traffic.
`timescale 1ns / 100ps

module tb_pointer_viewport_tracker_core;
    import pvt_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 8;
    localparam int MAX_PRINTS  = 40;

    localparam logic ACT_MOVE  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam int SZ_RANDOM = 0;
    localparam int SZ_MAX    = 1;
    localparam int SZ_MIN    = 2;
    localparam int SZ_WILD   = 3;

    typedef struct {
        logic [POS_W-1:0] pcol;
        logic [POS_W-1:0] prow;
        logic [4:0]       mask;
        logic             refresh;
        logic [POS_W-1:0] ocol;
        logic [POS_W-1:0] orow;
    } track_res_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow registers and tracker state
    logic [CFG_DATA_W-1:0] sh_view_cols, sh_view_rows, sh_remote_cols, sh_remote_rows;
    logic                  sh_paused;
    int                    cur_col, cur_row, win_left, win_top;

    track_res_t expected_q[$];
    int         err_count;
    int         cycle_count;
    int         src_idle_pct;
    int         snk_stall_pct;
    int         hold_req;

    pointer_viewport_tracker_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // pan one axis by half a window if the pointer left it, then hold the pointer inside
    task automatic pan_axis(inout int pos, inout int off, input int span, input int limit);
        int half;
        int o;
        half = span / 2;
        o = clamp_int(off, 0, limit - span);
        if (pos < o) begin
            o = o - half;
            if (o < 0) o = 0;
        end
        if (pos >= o + span && o + span < limit) begin
            o = o + half;
            if (o > limit - span) o = limit - span;
        end
        pos = clamp_int(pos, o, o + span - 1);
        off = o;
    endtask

    task automatic track_word(input logic act, input logic [7:0] btn, input logic [7:0] dx,
                              input logic [7:0] dy, input logic [7:0] wh);
        int vc, vr, rc, rr;
        int old_left, old_top;
        int whs;
        track_res_t r;
        rc = clamp_int(int'(sh_remote_cols), 1, MAX_SCREEN);
        rr = clamp_int(int'(sh_remote_rows), 1, MAX_SCREEN);
        vc = clamp_int(int'(sh_view_cols), 1, rc);
        vr = clamp_int(int'(sh_view_rows), 1, rr);
        if (act == ACT_START) begin
            cur_col  = vc / 2;
            cur_row  = vr / 2;
            win_left = 0;
            win_top  = 0;
            return;
        end
        if (sh_paused) return;
        old_left = win_left;
        old_top  = win_top;
        cur_col  = cur_col + int'($signed(dx));
        cur_row  = cur_row - int'($signed(dy));
        pan_axis(cur_col, win_left, vc, rc);
        pan_axis(cur_row, win_top, vr, rr);
        whs       = int'($signed(wh));
        r.pcol    = cur_col[POS_W-1:0];
        r.prow    = cur_row[POS_W-1:0];
        r.mask    = {whs < 0, whs > 0, btn[1], btn[2], btn[0]};
        r.refresh = (win_left != old_left) || (win_top != old_top);
        r.ocol    = win_left[POS_W-1:0];
        r.orow    = win_top[POS_W-1:0];
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH t=%0t %s: got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_pointer_viewport_tracker_core NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_check
        track_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[11:0] !== want.pcol)
                    report_mismatch("pointer_col", longint'(m_tdata[11:0]),
                                    longint'(want.pcol));
                if (m_tdata[23:12] !== want.prow)
                    report_mismatch("pointer_row", longint'(m_tdata[23:12]),
                                    longint'(want.prow));
                if (m_tdata[28:24] !== want.mask)
                    report_mismatch("button_mask", longint'(m_tdata[28:24]),
                                    longint'(want.mask));
                if (m_tdata[40:29] !== want.ocol)
                    report_mismatch("offset_col", longint'(m_tdata[40:29]),
                                    longint'(want.ocol));
                if (m_tdata[52:41] !== want.orow)
                    report_mismatch("offset_row", longint'(m_tdata[52:41]),
                                    longint'(want.orow));
                if (m_tdata[OUT_DATA_W-1:53] !== '0)
                    report_mismatch("tdata fill", longint'(m_tdata[OUT_DATA_W-1:53]), 0);
                if (m_tuser[0] !== want.refresh)
                    report_mismatch("refresh_needed", longint'(m_tuser[0]),
                                    longint'(want.refresh));
            end
        end
    end

    // receiver: random stalls, or a long hold-off counted here
    initial begin : sink_proc
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    task automatic send_word(input logic act, input logic [7:0] btn, input logic [7:0] dx,
                             input logic [7:0] dy, input logic [7:0] wh);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {wh, dy, dx, btn};
        do @(posedge aclk); while (!s_tready);
        track_word(act, btn, dx, dy, wh);
        @(negedge aclk);
    endtask

    task automatic send_random_word();
        logic [7:0] wh;
        wh = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
        send_word(($urandom_range(99) < 4) ? ACT_START : ACT_MOVE, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), wh);
    endtask

    // stop offering, wait for every expected word, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // leaves cfg_valid high; callers lower it after the last write
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_VIEW_COLS:   sh_view_cols   = val;
            REG_VIEW_ROWS:   sh_view_rows   = val;
            REG_REMOTE_COLS: sh_remote_cols = val;
            REG_REMOTE_ROWS: sh_remote_rows = val;
            REG_PAUSED:      sh_paused      = val[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic setup_sizes(input int kind);
        logic [CFG_DATA_W-1:0] vc, vr, rc, rr;
        case (kind)
            SZ_MAX: begin
                vc = 4096; vr = 4096; rc = 4096; rr = 4096;
            end
            SZ_MIN: begin
                vc = 1; vr = 1; rc = 1; rr = 1;
            end
            SZ_WILD: begin
                vc = 0; vr = 8191; rc = 8191; rr = 0;
            end
            default: begin
                rc = CFG_DATA_W'($urandom_range(1, 4096));
                rr = CFG_DATA_W'($urandom_range(1, 4096));
                vc = CFG_DATA_W'($urandom_range(1, (rc < 256) ? rc : 256));
                vr = CFG_DATA_W'($urandom_range(1, (rr < 256) ? rr : 256));
                if ($urandom_range(7) == 0) vc = CFG_DATA_W'($urandom_range(0, 8191));
                if ($urandom_range(7) == 0) rr = CFG_DATA_W'($urandom_range(0, 8191));
            end
        endcase
        write_reg(REG_VIEW_COLS, vc);
        write_reg(REG_VIEW_ROWS, vr);
        write_reg(REG_REMOTE_COLS, rc);
        write_reg(REG_REMOTE_ROWS, rr);
        write_reg(REG_PAUSED, '0);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_sizes_and_fields();
        send_word(ACT_MOVE, 8'hFF, 8'h7F, 8'h80, 8'h7F);
        send_word(ACT_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(ACT_MOVE, 8'h00, 8'h80, 8'h7F, 8'h80);
        send_word(ACT_MOVE, 8'h01, 8'h00, 8'h00, 8'h01);
        send_word(ACT_MOVE, 8'h02, 8'h01, 8'hFF, 8'hFF);
        send_word(ACT_MOVE, 8'h04, 8'hFF, 8'h01, 8'h00);
        send_word(ACT_MOVE, 8'hF8, 8'h00, 8'h00, 8'h00);
        drain();
    endtask

    task automatic test_panning();
        write_reg(REG_VIEW_COLS, 64);
        write_reg(REG_VIEW_ROWS, 48);
        write_reg(REG_REMOTE_COLS, 300);
        write_reg(REG_REMOTE_ROWS, 8191);
        cfg_valid <= 1'b0;
        send_word(ACT_START, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (3) send_word(ACT_MOVE, 8'h01, 8'h7F, 8'h00, 8'h00);
        repeat (2) send_word(ACT_MOVE, 8'h02, 8'h00, 8'h80, 8'h00);
        send_word(ACT_MOVE, 8'h04, 8'h80, 8'h00, 8'h00);
        send_word(ACT_MOVE, 8'h00, 8'h00, 8'h7F, 8'h00);
        drain();
    endtask

    // shrinking the remote screen leaves the stored offsets out of range
    task automatic test_stale_offsets();
        write_reg(REG_REMOTE_COLS, 64);
        write_reg(REG_REMOTE_ROWS, 48);
        cfg_valid <= 1'b0;
        send_word(ACT_MOVE, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();
    endtask

    task automatic test_odd_sizes();
        setup_sizes(SZ_WILD);
        send_word(ACT_MOVE, 8'h01, 8'h7F, 8'h7F, 8'h00);
        drain();
        write_reg(REG_VIEW_COLS, 1);
        write_reg(REG_REMOTE_COLS, 4096);
        write_reg(REG_VIEW_ROWS, 5000);
        write_reg(REG_REMOTE_ROWS, 100);
        cfg_valid <= 1'b0;
        send_word(ACT_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(ACT_MOVE, 8'h00, 8'h80, 8'h80, 8'h00);
        send_word(ACT_MOVE, 8'h00, 8'h7F, 8'h7F, 8'h00);
        drain();
    endtask

    task automatic test_paused();
        write_reg(REG_PAUSED, 1);
        cfg_valid <= 1'b0;
        send_word(ACT_MOVE, 8'hFF, 8'h7F, 8'h7F, 8'h7F);
        send_word(ACT_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(ACT_MOVE, 8'h07, 8'h80, 8'h80, 8'h80);
        drain();
        write_reg(REG_PAUSED, 0);
        cfg_valid <= 1'b0;
        send_word(ACT_MOVE, 8'h00, 8'h10, 8'hF0, 8'h00);
        drain();
    endtask

    // long receiver hold-off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        setup_sizes(SZ_RANDOM);
        hold_req = 300;
        repeat (60) send_random_word();
        drain();
    endtask

    // sender pauses with results outstanding until all of them are back
    task automatic test_sender_pause();
        src_idle_pct  = 0;
        snk_stall_pct = 50;
        repeat (20) send_random_word();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (20) send_random_word();
        drain();
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct, input int first_kind);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int seg = 0; seg < 4; seg++) begin
            drain();
            setup_sizes((seg == 0) ? first_kind : SZ_RANDOM);
            if ($urandom_range(3) == 0) begin
                write_reg(REG_PAUSED, 1);
                cfg_valid <= 1'b0;
                repeat (8) send_random_word();
                drain();
                write_reg(REG_PAUSED, 0);
                cfg_valid <= 1'b0;
            end
            repeat (50) send_random_word();
        end
        drain();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_MOVE;
        cfg_valid      = 1'b0;
        cfg_index      = REG_VIEW_COLS;
        cfg_data       = '0;
        sh_view_cols   = 640;
        sh_view_rows   = 480;
        sh_remote_cols = 640;
        sh_remote_rows = 480;
        sh_paused      = 1'b0;
        cur_col        = 0;
        cur_row        = 0;
        win_left       = 0;
        win_top        = 0;
        err_count      = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_req       = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_sizes_and_fields();
        test_panning();
        test_stale_offsets();
        test_odd_sizes();
        test_paused();
        test_backpressure();
        test_sender_pause();
        test_random_phase(0, 0, SZ_MAX);
        test_random_phase(81, 0, SZ_MIN);
        test_random_phase(0, 81, SZ_WILD);
        test_random_phase(15, 15, SZ_RANDOM);

        if (err_count == 0)
            $display("tb_pointer_viewport_tracker_core OK");
        else
            $display("tb_pointer_viewport_tracker_core NOT OK");
        $finish;
    end

endmodule
